// File: design/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: fork pair arbiter shared definitions
// Field widths, command and register codes, and reset values of the
// configuration registers.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int CMD_W      = 2;
    localparam int REQ_W      = 3;
    localparam int NOW_W      = 32;
    localparam int OUT_IDX_W  = 3;
    localparam int NUM_W      = 4;
    localparam int LIMIT_W    = 32;
    localparam int MEAL_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_NUM_REQ      = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STARVE_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MEAL_LIMIT   = 2'd2;

    localparam logic [NUM_W-1:0]   NUM_RESET    = 4'd5;
    localparam logic [LIMIT_W-1:0] STARVE_RESET = 32'd800;
    localparam logic [MEAL_W-1:0]  MEAL_RESET   = 16'd0;

endpackage

// File: design/fork_pair_arbiter_with_starvation_watch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fork_pair_arbiter_with_starvation_watch: ring pair arbiter
// Grants requester r resources r and r+1 (mod N) when both are free and no
// requester holds an older grant time; counts meals on release and flags the
// first requester whose time since its last grant exceeds the starve limit.
// ----------------------------------------------------------------------------
// One beat at a time: after a beat is accepted the block reads the entry of
// the addressed requester and then scans the stored grant times and meal
// counts of the N ring members through a single registered read port, one
// entry per cycle. The next beat is accepted only once the scan is over and
// the result has gone into the output register; the scan over the one read
// port thus sets the pace. A finished result may wait on the output register
// while the next beat is accepted and worked on.
module fork_pair_arbiter_with_starvation_watch #(
    parameter int MAX_REQUESTERS = 8,
    parameter int TIME_BITS      = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fpa_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [fpa_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [2:0] requester, [34:3] now, [39:35] zero
    input  logic [fpa_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // [1:0] command
    input  logic [fpa_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] granted, [1] starved, [4:2] starved_index, [5] all_full, [7:6] zero
    output logic [fpa_pkg::M_DATA_W-1:0]    m_axis_tdata
);
    import fpa_pkg::*;

    localparam int IDX_W = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
    localparam int N_W   = ($clog2(MAX_REQUESTERS + 1) > NUM_W) ?
                           $clog2(MAX_REQUESTERS + 1) : NUM_W;
    localparam int CMP_W = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_OWN,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic [NUM_W-1:0]      r_num;
    logic [LIMIT_W-1:0]    r_starve_limit;
    logic [MEAL_W-1:0]     r_meal_limit;

    logic [CMD_W-1:0]      r_cmd;
    logic [REQ_W-1:0]      r_req;
    logic [TIME_BITS-1:0]  r_t;
    logic [TIME_BITS-1:0]  r_own_time;

    logic [N_W-1:0]        r_i;
    logic                  r_eval;
    logic [IDX_W-1:0]      r_eidx;
    logic                  r_older;
    logic                  r_notfull;
    logic                  r_found;
    logic [IDX_W-1:0]      r_fidx;
    logic                  r_starve_seen;

    logic [MAX_REQUESTERS-1:0] r_busy;
    logic [MAX_REQUESTERS-1:0] r_tv;
    logic [MAX_REQUESTERS-1:0] r_mv;

    logic [TIME_BITS-1:0]  mem_time [MAX_REQUESTERS];
    logic [MEAL_W-1:0]     mem_meal [MAX_REQUESTERS];
    logic [TIME_BITS-1:0]  r_rd_time;
    logic [MEAL_W-1:0]     r_rd_meal;
    logic                  r_rd_tv;
    logic                  r_rd_mv;

    logic                  r_m_valid;
    logic                  r_o_granted;
    logic                  r_o_starved;
    logic [OUT_IDX_W-1:0]  r_o_index;
    logic                  r_o_full;

    logic [N_W-1:0]        w_n;
    logic [N_W-1:0]        w_req_n;
    logic [N_W-1:0]        w_nb_n;
    logic                  w_in_ring;
    logic [IDX_W-1:0]      w_ridx;
    logic [IDX_W-1:0]      w_nbidx;
    logic [IDX_W-1:0]      w_raddr;
    logic [TIME_BITS-1:0]  w_rd_time;
    logic [MEAL_W-1:0]     w_rd_meal;
    logic [MEAL_W-1:0]     w_meal_inc;
    logic [TIME_BITS-1:0]  w_diff;
    logic                  w_late;
    logic                  w_meal_we;
    logic                  w_fire;
    logic                  w_grant;
    logic                  w_mark;

    assign w_n       = (N_W'(r_num) > N_W'(MAX_REQUESTERS)) ? N_W'(MAX_REQUESTERS)
                                                            : N_W'(r_num);
    assign w_req_n   = N_W'(r_req);
    assign w_in_ring = (w_req_n < w_n);
    assign w_nb_n    = ((w_req_n + N_W'(1)) == w_n) ? '0 : (w_req_n + N_W'(1));
    assign w_ridx    = IDX_W'(r_req);
    assign w_nbidx   = IDX_W'(w_nb_n);
    assign w_raddr   = (r_state == ST_FETCH) ? w_ridx : r_i[IDX_W-1:0];

    assign w_rd_time  = r_rd_tv ? r_rd_time : '0;
    assign w_rd_meal  = r_rd_mv ? r_rd_meal : '0;
    assign w_meal_inc = w_rd_meal + MEAL_W'(1);
    assign w_diff     = r_t - w_rd_time;
    assign w_late     = (r_t >= w_rd_time) &&
                        (CMP_W'(w_diff) > CMP_W'(r_starve_limit));

    assign w_meal_we = (r_state == ST_OWN) && (r_cmd == CMD_RELEASE) && w_in_ring &&
                       (r_meal_limit != '0) && (w_rd_meal < r_meal_limit);
    assign w_fire    = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);
    assign w_grant   = (r_cmd == CMD_REQUEST) && (w_n > N_W'(1)) && w_in_ring &&
                       !r_busy[w_ridx] && !r_busy[w_nbidx] && !r_older;
    assign w_mark    = (r_cmd == CMD_CHECK) && !r_starve_seen && r_found;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_o_full, r_o_index, r_o_starved, r_o_granted};

    // grant time and meal count stores, one registered read port
    always_ff @(posedge i_clk) begin
        r_rd_time <= mem_time[w_raddr];
        r_rd_meal <= mem_meal[w_raddr];
        if (w_meal_we) begin
            mem_meal[w_ridx] <= w_meal_inc;
        end
        if (w_fire && w_grant) begin
            mem_time[w_ridx] <= r_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_num          <= NUM_RESET;
            r_starve_limit <= STARVE_RESET;
            r_meal_limit   <= MEAL_RESET;
            r_busy         <= '0;
            r_tv           <= '0;
            r_mv           <= '0;
            r_starve_seen  <= 1'b0;
            r_m_valid      <= 1'b0;
            r_eval         <= 1'b0;
            r_rd_tv        <= 1'b0;
            r_rd_mv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NUM_REQ:      r_num          <= i_cfg_wdata[NUM_W-1:0];
                    CFG_STARVE_LIMIT: r_starve_limit <= i_cfg_wdata[LIMIT_W-1:0];
                    CFG_MEAL_LIMIT:   r_meal_limit   <= i_cfg_wdata[MEAL_W-1:0];
                    default: ;
                endcase
            end
            if (r_m_valid && m_axis_tready && !w_fire) begin
                r_m_valid <= 1'b0;
            end
            r_rd_tv <= r_tv[w_raddr];
            r_rd_mv <= r_mv[w_raddr];
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tuser;
                        r_req   <= s_axis_tdata[REQ_W-1:0];
                        r_t     <= TIME_BITS'(s_axis_tdata[REQ_W +: NOW_W]);
                        r_state <= ST_FETCH;
                    end
                end
                ST_FETCH: begin
                    r_state <= ST_OWN;
                end
                ST_OWN: begin
                    r_own_time <= w_rd_time;
                    if (w_meal_we) begin
                        r_mv[w_ridx] <= 1'b1;
                    end
                    r_i       <= '0;
                    r_eval    <= 1'b0;
                    r_older   <= 1'b0;
                    r_notfull <= 1'b0;
                    r_found   <= 1'b0;
                    r_fidx    <= '0;
                    r_state   <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (r_eval) begin
                        if (w_rd_time < r_own_time) begin
                            r_older <= 1'b1;
                        end
                        if (w_rd_meal < r_meal_limit) begin
                            r_notfull <= 1'b1;
                        end
                        if (!r_found && w_late) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_eidx;
                        end
                    end
                    if (r_i < w_n) begin
                        r_eval <= 1'b1;
                        r_eidx <= r_i[IDX_W-1:0];
                        r_i    <= r_i + N_W'(1);
                    end else begin
                        r_eval <= 1'b0;
                        if (!r_eval) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (w_fire) begin
                        r_m_valid   <= 1'b1;
                        r_o_granted <= w_grant;
                        r_o_starved <= r_starve_seen || w_mark;
                        r_o_index   <= w_mark ? OUT_IDX_W'(r_fidx) : '0;
                        r_o_full    <= (r_meal_limit != '0) && !r_notfull;
                        if (w_grant) begin
                            r_busy[w_ridx]  <= 1'b1;
                            r_busy[w_nbidx] <= 1'b1;
                            r_tv[w_ridx]    <= 1'b1;
                        end
                        if ((r_cmd == CMD_RELEASE) && w_in_ring) begin
                            r_busy[w_ridx]  <= 1'b0;
                            r_busy[w_nbidx] <= 1'b0;
                        end
                        if (w_mark) begin
                            r_starve_seen <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_grant_only_on_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_grant) |-> (r_cmd == CMD_REQUEST))
        else $error("grant reported for a beat that was not a request");

    a_index_needs_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && (r_o_index != '0)) |-> r_o_starved)
        else $error("starved index without starvation mark");

    a_mark_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_starve_seen |=> r_starve_seen)
        else $error("starvation mark cleared");

    a_grant_takes_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_grant) |=> (r_busy[w_ridx] && r_busy[w_nbidx]))
        else $error("granted pair not marked busy");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_i <= w_n))
        else $error("scan index ran past ring size");
`endif

endmodule

// File: bench/fork_pair_arbiter_with_starvation_watch_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fork_pair_arbiter_with_starvation_watch_tb: ring pair arbiter testbench
// Drives request, release and starvation-check beats into the arbiter. A
// behavioral model in the bench works out the verdict of each accepted beat,
// and every output beat is checked field by field against it. A directed
// part covers ring size edges, meal counting and the starvation watch. It is
// followed by random traffic in several register settings, with random
// stalls on both streams.
// ----------------------------------------------------------------------------
module fork_pair_arbiter_with_starvation_watch_tb;
    import fpa_pkg::*;

    localparam int  CLK_HALF    = 2;
    localparam int  SETTLE      = 16;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  RING_MAX    = 8;
    localparam int  PHASE_BEATS = 240;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]           pad;
        logic                 all_full;
        logic [OUT_IDX_W-1:0] starved_index;
        logic                 starved;
        logic                 granted;
    } t_verdict;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [2:0] requester, [34:3] now, [39:35] zero
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    // [1:0] command
    logic [CMD_W-1:0]      s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] granted, [1] starved, [4:2] starved_index, [5] all_full, [7:6] zero
    logic [M_DATA_W-1:0]   m_axis_tdata;

    // arbiter model state
    logic [NUM_W-1:0]   cfg_ring_n     = NUM_RESET;
    logic [LIMIT_W-1:0] cfg_starve_lim = STARVE_RESET;
    logic [MEAL_W-1:0]  cfg_meal_lim   = MEAL_RESET;
    bit                 fork_busy  [RING_MAX];
    logic [NOW_W-1:0]   grant_time [RING_MAX];
    logic [MEAL_W-1:0]  meals      [RING_MAX];
    bit                 starve_mark;

    t_verdict           expected_verdicts[$];
    bit                 holding[RING_MAX];
    logic [NOW_W-1:0]   sim_ms = 32'd3000;
    bit                 calm;
    int                 mismatches;
    int                 verdicts_seen;
    int                 cycles;

    fork_pair_arbiter_with_starvation_watch u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    function automatic int ring_size();
        return (cfg_ring_n > RING_MAX) ? RING_MAX : int'(cfg_ring_n);
    endfunction

    function automatic t_verdict predict_verdict(input logic [CMD_W-1:0] cmd,
                                                 input logic [REQ_W-1:0] req,
                                                 input logic [NOW_W-1:0] now);
        t_verdict v;
        int       n;
        int       r;
        int       nb;
        bit       ok;
        v = '0;
        n = ring_size();
        r = int'(req);
        case (cmd)
            CMD_REQUEST: begin
                if (n > 1 && r < n) begin
                    nb = (r + 1) % n;
                    ok = !fork_busy[r] && !fork_busy[nb];
                    for (int i = 0; i < n; i++) begin
                        if (grant_time[i] < grant_time[r]) ok = 1'b0;
                    end
                    if (ok) begin
                        fork_busy[r]  = 1'b1;
                        fork_busy[nb] = 1'b1;
                        grant_time[r] = now;
                        v.granted     = 1'b1;
                    end
                end
            end
            CMD_RELEASE: begin
                if (r < n) begin
                    fork_busy[r]           = 1'b0;
                    fork_busy[(r + 1) % n] = 1'b0;
                    if (cfg_meal_lim != 0 && meals[r] < cfg_meal_lim) meals[r] = meals[r] + 1'b1;
                end
            end
            CMD_CHECK: begin
                if (!starve_mark) begin
                    for (int i = 0; i < n; i++) begin
                        if (!starve_mark && now >= grant_time[i] &&
                            (now - grant_time[i]) > cfg_starve_lim) begin
                            starve_mark     = 1'b1;
                            v.starved_index = OUT_IDX_W'(i);
                        end
                    end
                end
            end
            default: ;
        endcase
        v.starved = starve_mark;
        if (cfg_meal_lim != 0) begin
            v.all_full = 1'b1;
            for (int i = 0; i < n; i++) begin
                if (meals[i] < cfg_meal_lim) v.all_full = 1'b0;
            end
        end
        return v;
    endfunction

    // --- stream drivers ----------------------------------------------------

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] req,
                             input logic [NOW_W-1:0] now);
        t_verdict v;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < 26) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(S_DATA_W - NOW_W - REQ_W){1'b0}}, now, req};
        do @(posedge i_clk); while (!s_axis_tready);
        v = predict_verdict(cmd, req, now);
        expected_verdicts.push_back(v);
        if (cmd == CMD_REQUEST && v.granted) holding[req] = 1'b1;
        if (cmd == CMD_RELEASE) holding[req] = 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            CFG_NUM_REQ:      cfg_ring_n     = value[NUM_W-1:0];
            CFG_STARVE_LIMIT: cfg_starve_lim = value[LIMIT_W-1:0];
            CFG_MEAL_LIMIT:   cfg_meal_lim   = value[MEAL_W-1:0];
            default: ;
        endcase
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 26);
    end

    // --- result checker ----------------------------------------------------

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("mismatch on beat %0d: %s", verdicts_seen, msg);
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) note_mismatch($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    always @(posedge i_clk) begin : verdict_check
        t_verdict got;
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_verdict'(m_axis_tdata);
            if (expected_verdicts.size() == 0) begin
                note_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
            end else begin
                want = expected_verdicts.pop_front();
                compare_field("granted", want.granted, got.granted);
                compare_field("starved", want.starved, got.starved);
                compare_field("starved_index", want.starved_index, got.starved_index);
                compare_field("all_full", want.all_full, got.all_full);
                compare_field("pad", want.pad, got.pad);
            end
            verdicts_seen++;
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // --- tests -------------------------------------------------------------

    task automatic test_request_and_release();
        send_beat(CMD_REQUEST, 3'd0, 32'h0000_0000);
        send_beat(CMD_REQUEST, 3'd7, 32'd5);            // outside ring of 5
        send_beat(CMD_RELEASE, 3'd7, 32'd6);
        send_beat(CMD_UNUSED,  3'd2, 32'hFFFF_FFFF);
        send_beat(CMD_REQUEST, 3'd4, 32'hFFFF_FFFF);    // neighbor fork held
        send_beat(CMD_RELEASE, 3'd1, 32'd7);            // release without hold
        send_beat(CMD_RELEASE, 3'd0, 32'd8);
    endtask

    task automatic test_ring_size_edges();
        write_reg(CFG_NUM_REQ, 32'd0);
        write_reg(CFG_MEAL_LIMIT, 32'd3);
        send_beat(CMD_REQUEST, 3'd0, 32'd1);
        send_beat(CMD_CHECK,   3'd0, 32'hFFFF_FFFF);
        write_reg(CFG_NUM_REQ, 32'd1);
        send_beat(CMD_REQUEST, 3'd0, 32'd2);
        send_beat(CMD_RELEASE, 3'd0, 32'd3);
        write_reg(CFG_NUM_REQ, 32'd15);                 // saturates at eight
        write_reg(CFG_MEAL_LIMIT, 32'd0);
        send_beat(CMD_REQUEST, 3'd7, 32'd300);
    endtask

    task automatic test_meal_counting();
        write_reg(CFG_NUM_REQ, 32'd2);
        write_reg(CFG_MEAL_LIMIT, 32'd2);
        send_beat(CMD_RELEASE, 3'd0, 32'd10);
        send_beat(CMD_RELEASE, 3'd1, 32'd11);
        send_beat(CMD_RELEASE, 3'd1, 32'd12);
        send_beat(CMD_RELEASE, 3'd1, 32'd13);           // saturated
        write_reg(CFG_MEAL_LIMIT, 32'd1);               // lowered to or below counts
        send_beat(CMD_RELEASE, 3'd0, 32'd14);
        write_reg(CFG_MEAL_LIMIT, 32'd65535);
        send_beat(CMD_REQUEST, 3'd1, 32'd0);
    endtask

    task automatic test_starvation_watch();
        write_reg(CFG_NUM_REQ, 32'd3);
        write_reg(CFG_MEAL_LIMIT, 32'd0);
        send_beat(CMD_REQUEST, 3'd2, 32'd100);
        send_beat(CMD_RELEASE, 3'd2, 32'd101);
        send_beat(CMD_REQUEST, 3'd0, 32'd2000);
        send_beat(CMD_RELEASE, 3'd0, 32'd2001);
        send_beat(CMD_REQUEST, 3'd2, 32'd2002);         // older grant exists
        write_reg(CFG_STARVE_LIMIT, 32'd0);
        send_beat(CMD_CHECK, 3'd0, 32'd0);              // time behind grants
        write_reg(CFG_STARVE_LIMIT, 32'hFFFF_FFFF);
        send_beat(CMD_CHECK, 3'd0, 32'hFFFF_FFFF);
        write_reg(CFG_STARVE_LIMIT, 32'd1000);
        send_beat(CMD_CHECK, 3'd0, 32'd1000);           // exactly at limit
        send_beat(CMD_CHECK, 3'd0, 32'd1001);
        send_beat(CMD_CHECK, 3'd0, 32'd5000);           // mark is sticky
    endtask

    task automatic send_random_beat();
        logic [CMD_W-1:0] cmd;
        logic [REQ_W-1:0] req;
        logic [NOW_W-1:0] now;
        int               n;
        int               pick;
        int               oldest;
        n    = ring_size();
        pick = $urandom_range(0, 99);
        if (pick < 10 || n == 0) begin
            cmd = CMD_W'($urandom_range(0, 3));
            req = REQ_W'($urandom_range(0, 7));
            now = $urandom();
        end else begin
            sim_ms = sim_ms + $urandom_range(0, 60);
            now    = sim_ms;
            req    = REQ_W'($urandom_range(0, n - 1));
            if (pick < 45) begin
                cmd = CMD_RELEASE;
                for (int i = 0; i < n; i++) begin
                    if (holding[i] && $urandom_range(0, 1)) req = REQ_W'(i);
                end
            end else if (pick < 88) begin
                cmd = CMD_REQUEST;
                if (pick < 72) begin
                    oldest = 0;
                    for (int i = 1; i < n; i++) begin
                        if (grant_time[i] < grant_time[oldest]) oldest = i;
                    end
                    req = REQ_W'(oldest);
                end
            end else begin
                cmd = CMD_CHECK;
            end
        end
        send_beat(cmd, req, now);
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] ring_n;
        logic [CFG_DATA_W-1:0] limit;
        logic [CFG_DATA_W-1:0] meal;
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin ring_n = 8;  limit = 32'hFFFF_FFFF; meal = 0;     end
                1: begin ring_n = 5;  limit = $urandom();    meal = 3;     end
                2: begin ring_n = 2;  limit = 0;             meal = 1;     end
                3: begin ring_n = 15; limit = 800;           meal = 65535; end
                4: begin ring_n = 3;  limit = $urandom();    meal = 2;     end
                default: begin
                    ring_n = $urandom_range(2, 15);
                    limit  = $urandom();
                    meal   = $urandom_range(0, 4);
                end
            endcase
            write_reg(CFG_NUM_REQ, ring_n);
            write_reg(CFG_STARVE_LIMIT, limit);
            write_reg(CFG_MEAL_LIMIT, meal);
            holding = '{default: 1'b0};
            calm    = (p == 0);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (p == 4 && k == PHASE_BEATS / 2) wait_idle();
                send_random_beat();
            end
        end
        calm = 1'b0;
    endtask

    initial begin : main
        fork_busy   = '{default: 1'b0};
        grant_time  = '{default: '0};
        meals       = '{default: '0};
        holding     = '{default: 1'b0};
        starve_mark = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_request_and_release();
        test_ring_size_edges();
        test_meal_counting();
        test_starvation_watch();
        test_random_traffic();

        wait_idle();
        repeat (2 * SETTLE) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/fpa_pkg.sv
design/fork_pair_arbiter_with_starvation_watch.sv
bench/fork_pair_arbiter_with_starvation_watch_tb.sv
